### design/ibhq_pkg.sv
// ----------------------------------------------------------------------------
// ibhq_pkg
// Shared constants and helpers of the indexed binary heap queue.
// ----------------------------------------------------------------------------
package ibhq_pkg;
  localparam int CAPACITY = 64;
  localparam int PRIORITY_WIDTH = 32;
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int ID_W = 6;
  localparam int NUM_IDS = 1 << ID_W;
  localparam int HEAP_W = ID_W + PRIORITY_WIDTH;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_CHANGE = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_DUP = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [PRIORITY_WIDTH-1:0] pri_t;

  // true when a ranks strictly worse than b
  function automatic logic ranks_worse(input pri_t a, input pri_t b, input logic max_first);
    logic lt;
    logic gt;
    lt = $signed(a) < $signed(b);
    gt = $signed(a) > $signed(b);
    return max_first ? lt : gt;
  endfunction
endpackage

### design/indexed_binary_heap_queue_unit.sv
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue_unit
// Indexed binary-heap priority queue with insert, pop and change priority.
// ----------------------------------------------------------------------------
// One transaction at a time. The heap contents sit in two RAMs with registered
// read data: a heap RAM (id and priority per slot) and a position RAM per id.
// Each heap read issues its address and then waits for the read data. A sift-up
// level reads the parent and compares; a sift-down level reads the left child
// and, when there is one, the right child, then compares. The position RAM needs
// a clearing pass over all 64 ids after reset, during which s_tready is low.
module indexed_binary_heap_queue_unit
  import ibhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // command[1:0], item_id[7:2], priority_req[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // out_id[5:0], out_priority[37:6], status[40:38],
                                 // count[47:41]
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_POS = 4'd2, S_DEC = 4'd3,
    S_UPRD = 4'd4, S_UPCK = 4'd5, S_DNL = 4'd6, S_DNR = 4'd7, S_DNCK = 4'd8,
    S_DONE = 4'd9, S_OUT = 4'd10, S_POPRD = 4'd11, S_POPLAST = 4'd12,
    S_HDRD = 4'd13, S_HDW = 4'd14;

  logic [3:0] state;
  logic order_mode;
  logic [1:0] cmd;
  logic [ID_W-1:0] cid;
  pri_t cpri;
  slot_t count, cur, kid;
  logic [ID_W-1:0] mid;      // moving item
  pri_t mpri;
  logic [ID_W-1:0] hid;
  pri_t lpri, hpri;
  logic [ID_W-1:0] oid;
  pri_t opri;
  logic [2:0] ost;
  logic [ID_W:0] clr;

  logic h_we; slot_t h_wa, h_ra; logic [HEAP_W-1:0] h_wd, h_rd;
  logic p_we; logic [ID_W-1:0] p_wa, p_ra; slot_t p_wd, p_rd;

  ibhq_ram #(.WIDTH(HEAP_W), .DEPTH(1 << SLOT_W)) u_heap (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  ibhq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_IDS)) u_pos (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  logic [ID_W-1:0] rid;
  pri_t rpri;
  assign rid = h_rd[ID_W-1:0];
  assign rpri = h_rd[HEAP_W-1:ID_W];

  logic wait1;
  logic up_go;
  logic dn_right;
  slot_t kl;
  assign kl = {cur[SLOT_W-2:0], 1'b0};
  assign up_go = ranks_worse(rpri, mpri, order_mode);

  always_comb begin
    h_we = 1'b0; h_wa = cur; h_wd = {mpri, mid}; h_ra = cur;
    p_we = 1'b0; p_wa = mid; p_wd = cur; p_ra = cid;
    unique case (state)
      S_CLR: begin
        p_we = 1'b1; p_wa = clr[ID_W-1:0]; p_wd = '0;
      end
      S_IDLE: p_ra = s_tdata[7:2];
      S_UPRD: h_ra = cur >> 1;
      S_UPCK: begin
        h_ra = cur >> 1;
        if (!wait1 && up_go) begin
          h_we = 1'b1; h_wd = h_rd; p_we = 1'b1; p_wa = rid;
        end
      end
      S_DNL: h_ra = kl;
      S_DNR: h_ra = kl;
      S_HDRD: h_ra = kl + slot_t'(1);
      S_DNCK: if (!wait1 && ranks_worse(mpri, hpri, order_mode)) begin
        h_we = 1'b1; h_wd = {hpri, hid}; p_we = 1'b1; p_wa = hid;
      end
      S_DONE: begin
        h_we = 1'b1; p_we = 1'b1;
      end
      S_POPRD: h_ra = slot_t'(1);
      S_POPLAST: h_ra = count;
      S_HDW: begin
        p_we = 1'b1; p_wa = oid; p_wd = '0;
      end
      S_POS: h_ra = p_rd;
      default: ;
    endcase
  end

  assign dn_right = ranks_worse(lpri, rpri, order_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr <= '0; order_mode <= 1'b0; count <= '0; wait1 <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_mode <= cfg_wdata;
      end
      unique case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (ID_W + 1)'(NUM_IDS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid) begin
          cmd <= s_tdata[1:0]; cid <= s_tdata[7:2]; cpri <= s_tdata[39:8];
          oid <= s_tdata[7:2]; opri <= '0; ost <= ST_OK;
          state <= S_DEC;
        end
        S_DEC: begin
          unique case (cmd)
            CMD_INSERT: begin
              if (p_rd != '0) begin
                ost <= ST_DUP; state <= S_OUT;
              end else if (count == slot_t'(CAPACITY)) begin
                ost <= ST_FULL; state <= S_OUT;
              end else begin
                count <= count + 1'b1; cur <= count + 1'b1;
                mid <= cid; mpri <= cpri; wait1 <= 1'b1; state <= S_UPRD;
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                ost <= ST_EMPTY; state <= S_OUT;
              end else begin
                wait1 <= 1'b1; state <= S_POPRD;
              end
            end
            CMD_CHANGE: begin
              if (p_rd == '0 || p_rd > count) begin
                ost <= ST_ABSENT; state <= S_OUT;
              end else begin
                cur <= p_rd; mid <= cid; mpri <= cpri; wait1 <= 1'b1; state <= S_POS;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_POS: begin
          if (wait1) begin
            wait1 <= 1'b0;
          end else if (ranks_worse(rpri, mpri, order_mode)) begin
            wait1 <= 1'b1; state <= S_UPRD;
          end else begin
            wait1 <= 1'b1; state <= S_DNL;
          end
        end
        S_UPRD: begin
          if (cur <= slot_t'(1)) state <= S_DONE;
          else begin
            wait1 <= 1'b1; state <= S_UPCK;
          end
        end
        S_UPCK: begin
          if (wait1) wait1 <= 1'b0;
          else if (up_go) begin
            cur <= cur >> 1; state <= S_UPRD;
          end else state <= S_DONE;
        end
        S_POPRD: begin
          if (wait1) wait1 <= 1'b0;
          else begin
            oid <= rid; opri <= rpri; wait1 <= 1'b1; state <= S_POPLAST;
          end
        end
        S_POPLAST: begin
          if (wait1) wait1 <= 1'b0;
          else begin
            mid <= rid; mpri <= rpri; count <= count - 1'b1; cur <= slot_t'(1);
            state <= S_DNL;
          end
        end
        S_DNL: begin
          if (kl > count || kl == '0) state <= S_DONE;
          else begin
            wait1 <= 1'b1; state <= S_DNR;
          end
        end
        S_DNR: begin
          if (wait1) wait1 <= 1'b0;
          else begin
            lpri <= rpri; hid <= rid; hpri <= rpri; kid <= kl;
            if (kl + slot_t'(1) <= count) begin
              wait1 <= 1'b1; state <= S_HDRD;
            end else state <= S_DNCK;
          end
        end
        S_HDRD: begin
          if (wait1) wait1 <= 1'b0;
          else begin
            if (dn_right) begin
              hid <= rid; hpri <= rpri; kid <= kl + slot_t'(1);
            end
            state <= S_DNCK;
          end
        end
        S_DNCK: begin
          if (ranks_worse(mpri, hpri, order_mode)) begin
            cur <= kid; state <= S_DNL;
          end else state <= S_DONE;
        end
        S_DONE: state <= (cmd == CMD_POP) ? S_HDW : S_OUT;
        S_HDW: state <= S_OUT;
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // right child read uses address kl+1 in S_HDRD
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {7'(count), ost, opri, oid};

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready)) else $error("output and input both open");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    count <= slot_t'(CAPACITY)) else $error("count over capacity");
  property p_hold;
    @(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata);
  endproperty
  a_hold: assert property (p_hold) else $error("result dropped");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(count)) else $error("count moved while idle");
endmodule

### design/ibhq_ram.sv
// ----------------------------------------------------------------------------
// ibhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
